### hdl/btq_pkg.sv
// Package: shared types and codes for the blocked task queue.
package btq_pkg;

    typedef enum logic [2:0] {
        FUNC_PUT_PLAIN = 3'd0,
        FUNC_PUT_SLEEP = 3'd1,
        FUNC_PUT_WAIT  = 3'd2,
        FUNC_GET       = 3'd3,
        FUNC_TICK      = 3'd4,
        FUNC_MARK      = 3'd5,
        FUNC_CLEAR     = 3'd6,
        FUNC_NOP       = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_SLEEP = 2'd1,
        KIND_WAIT  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DEQUEUED = 2'd0,
        ST_WOKEN    = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT,
        S_CLEAR
    } state_t;

    typedef struct packed {
        logic [7:0]  task_id;
        kind_t       kind;
        logic [15:0] ticks;
        logic [7:0]  awaited;
    } entry_t;

    // input item
    typedef struct packed {
        func_t       func;
        logic [7:0]  task_id;
        logic [15:0] sleep_ticks;
        logic [7:0]  awaited_id;
    } req_t;

    // result item
    typedef struct packed {
        logic [7:0] out_id;
        status_t    status;
        logic       last;
    } rsp_t;

    // control from the sequencer to every cell
    typedef struct packed {
        logic load;   // write new entry at the tail cell
        logic pop;    // shift everything toward the head
        logic rot;    // rotate: head leaves, re-enters at the tail unless dropped
        logic keep;   // rotating head is kept
    } cell_ctl_t;

endpackage

### hdl/btq_if.sv
// Interface: valid/ready channel carrying a generic payload.
interface btq_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hdl/btq_cell.sv
// Cell: one queue slot, shifting toward the head on pop or rotate.
module btq_cell (
    input  logic                clk,
    input  btq_pkg::cell_ctl_t  ctl,
    input  logic                is_tail,    // this slot takes a load
    input  logic                is_rot_dst, // this slot takes the rotated head
    input  btq_pkg::entry_t     new_entry,
    input  btq_pkg::entry_t     head_entry,
    input  btq_pkg::entry_t     from_next,
    output btq_pkg::entry_t     value
);
    btq_pkg::entry_t entry_reg;
    btq_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load && is_tail)
        begin
            entry_next = new_entry;
        end
        else if (ctl.rot && ctl.keep && is_rot_dst)
        begin
            entry_next = head_entry;
        end
        else if (ctl.pop || ctl.rot)
        begin
            entry_next = from_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign value = entry_reg;
endmodule

### hdl/blocked_task_queue.sv
// Top level: blocked task queue built from a chain of slot cells.
// in_ch carries func, task_id, sleep_ticks, awaited_id; out_ch carries
// out_id, status, last. An item moves on a clock edge with valid and ready high.
// One input item is handled at a time. Puts, get, mark and clear are done
// in the idle state; a get, or a put into a full queue, leaves its one
// result in the output register for the next cycle.
// A tick walks the chain: for each queued entry the head cell is examined
// and either taken out as woken or rotated back to the tail, then an emit
// state finishes before the next item is taken. Woken tasks leave in queue
// order, each held back in pend until the next one is woken or the walk
// ends, so last can be set on the final one.
// A stalled receiver holds the walk and the input for each stalled cycle
// while a result is waiting; nothing is lost.
// After reset a clearing pass over all TASK_COUNT marks (256 by default) zeroes
// the finished marks before in_ch becomes ready; slot contents are not reset.
module blocked_task_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TASK_COUNT  = 256
) (
    input  logic clk,
    input  logic rst_n,
    btq_if.sink   in_ch,
    btq_if.source out_ch
);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

    btq_pkg::state_t   state_reg, state_next;
    logic [OW-1:0]     occ_reg, occ_next;
    logic [OW-1:0]     cnt_reg, cnt_next;
    logic [OW-1:0]     kept_reg, kept_next;
    logic              woke_any_reg, woke_any_next;
    logic [7:0]        pend_reg, pend_next;
    logic [TW-1:0]     clr_reg, clr_next;

    logic              fin_mem [TASK_COUNT];
    logic              fin_rd_reg;
    logic              fin_we;
    logic              fin_wdata;
    logic [TW-1:0]     fin_waddr;
    logic [TW-1:0]     fin_raddr;

    logic              ov_reg, ov_next;
    logic [7:0]        oid_reg, oid_next;
    btq_pkg::status_t  ost_reg, ost_next;
    logic              olast_reg, olast_next;

    btq_pkg::entry_t   cells [QUEUE_DEPTH];
    btq_pkg::entry_t   new_entry;
    btq_pkg::entry_t   head_upd;
    btq_pkg::cell_ctl_t ctl;
    btq_pkg::func_t    func;
    logic              wake;
    logic              out_free;

    assign func = btq_pkg::func_t'(in_ch.payload.func);
    assign out_free = !ov_reg || out_ch.ready;

    // mark of the entry that is head at the next edge during a tick walk
    always_comb
    begin
        fin_raddr = cells[0].awaited[TW-1:0];
        if (state_reg == btq_pkg::S_WALK && out_free)
        begin
            fin_raddr = cells[1].awaited[TW-1:0];
        end
    end

    // head evaluation during the tick walk
    always_comb
    begin
        head_upd = cells[0];
        wake = 1'b0;
        if (cells[0].kind == btq_pkg::KIND_SLEEP)
        begin
            if (cells[0].ticks != 16'd0)
            begin
                head_upd.ticks = cells[0].ticks - 16'd1;
            end
            wake = (head_upd.ticks == 16'd0);
        end
        else if (cells[0].kind == btq_pkg::KIND_WAIT)
        begin
            wake = (32'(cells[0].awaited) < 32'(TASK_COUNT)) && fin_rd_reg;
        end
    end

    always_comb
    begin
        new_entry.task_id = in_ch.payload.task_id;
        new_entry.kind    = btq_pkg::KIND_PLAIN;
        new_entry.ticks   = 16'd0;
        new_entry.awaited = 8'd0;
        unique case (func)
            btq_pkg::FUNC_PUT_SLEEP:
            begin
                new_entry.kind  = btq_pkg::KIND_SLEEP;
                new_entry.ticks = in_ch.payload.sleep_ticks;
            end
            btq_pkg::FUNC_PUT_WAIT:
            begin
                new_entry.kind    = btq_pkg::KIND_WAIT;
                new_entry.awaited = in_ch.payload.awaited_id;
            end
            default:
            begin
            end
        endcase
    end

    assign in_ch.ready = (state_reg == btq_pkg::S_IDLE) && out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            btq_pkg::S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready && func == btq_pkg::FUNC_TICK
                    && occ_reg != '0)
                begin
                    state_next = btq_pkg::S_WALK;
                end
            end
            btq_pkg::S_WALK:
            begin
                if (out_free && cnt_reg == OW'(1))
                begin
                    state_next = btq_pkg::S_EMIT;
                end
            end
            btq_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = btq_pkg::S_IDLE;
                end
            end
            btq_pkg::S_CLEAR:
            begin
                if (clr_reg == TW'(TASK_COUNT - 1))
                begin
                    state_next = btq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = btq_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        ctl = '0;
        occ_next = occ_reg;
        cnt_next = cnt_reg;
        kept_next = kept_reg;
        woke_any_next = woke_any_reg;
        pend_next = pend_reg;
        clr_next = clr_reg;
        fin_we = 1'b0;
        fin_wdata = 1'b0;
        fin_waddr = in_ch.payload.task_id[TW-1:0];
        ov_next = ov_reg && !out_ch.ready;
        oid_next = oid_reg;
        ost_next = ost_reg;
        olast_next = olast_reg;
        unique case (state_reg)
            btq_pkg::S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    case (func) inside
                        btq_pkg::FUNC_PUT_PLAIN, btq_pkg::FUNC_PUT_SLEEP,
                        btq_pkg::FUNC_PUT_WAIT:
                        begin
                            if (occ_reg == OW'(QUEUE_DEPTH))
                            begin
                                ov_next = 1'b1;
                                oid_next = in_ch.payload.task_id;
                                ost_next = btq_pkg::ST_FULL;
                                olast_next = 1'b1;
                            end
                            else
                            begin
                                ctl.load = 1'b1;
                                occ_next = occ_reg + OW'(1);
                            end
                        end
                        btq_pkg::FUNC_GET:
                        begin
                            ov_next = 1'b1;
                            olast_next = 1'b1;
                            if (occ_reg == '0)
                            begin
                                oid_next = 8'd0;
                                ost_next = btq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                oid_next = cells[0].task_id;
                                ost_next = btq_pkg::ST_DEQUEUED;
                                ctl.pop = 1'b1;
                                occ_next = occ_reg - OW'(1);
                            end
                        end
                        btq_pkg::FUNC_TICK:
                        begin
                            cnt_next = occ_reg;
                            kept_next = '0;
                            woke_any_next = 1'b0;
                        end
                        btq_pkg::FUNC_MARK:
                        begin
                            if (32'(in_ch.payload.task_id) < 32'(TASK_COUNT))
                            begin
                                fin_we = 1'b1;
                                fin_wdata = 1'b1;
                            end
                        end
                        btq_pkg::FUNC_CLEAR:
                        begin
                            if (32'(in_ch.payload.task_id) < 32'(TASK_COUNT))
                            begin
                                fin_we = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            btq_pkg::S_WALK:
            begin
                // the latest woken task waits in pend until the next one or the end
                if (out_free)
                begin
                    ctl.rot = 1'b1;
                    ctl.keep = !wake;
                    cnt_next = cnt_reg - OW'(1);
                    if (wake)
                    begin
                        if (woke_any_reg)
                        begin
                            ov_next = 1'b1;
                            oid_next = pend_reg;
                            ost_next = btq_pkg::ST_WOKEN;
                            olast_next = 1'b0;
                        end
                        woke_any_next = 1'b1;
                        pend_next = head_upd.task_id;
                        occ_next = occ_reg - OW'(1);
                    end
                    else
                    begin
                        kept_next = kept_reg + OW'(1);
                    end
                end
            end
            btq_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    occ_next = kept_reg;
                    if (woke_any_reg)
                    begin
                        ov_next = 1'b1;
                        oid_next = pend_reg;
                        ost_next = btq_pkg::ST_WOKEN;
                        olast_next = 1'b1;
                    end
                end
            end
            btq_pkg::S_CLEAR:
            begin
                fin_we = 1'b1;
                fin_waddr = clr_reg;
                clr_next = clr_reg + TW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // chain of cells
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        btq_pkg::entry_t nxt;
        logic tail, rdst;
        assign nxt = (g == QUEUE_DEPTH - 1) ? cells[g] : cells[(g + 1) % QUEUE_DEPTH];
        assign tail = (occ_reg[OW-1:0] == OW'(g));
        assign rdst = ((occ_reg - OW'(1)) == OW'(g));
        btq_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .is_tail    (tail),
            .is_rot_dst (rdst),
            .new_entry  (new_entry),
            .head_entry (head_upd),
            .from_next  (nxt),
            .value      (cells[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= btq_pkg::S_CLEAR;
            occ_reg      <= '0;
            cnt_reg      <= '0;
            kept_reg     <= '0;
            woke_any_reg <= 1'b0;
            clr_reg      <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            cnt_reg      <= cnt_next;
            kept_reg     <= kept_next;
            woke_any_reg <= woke_any_next;
            clr_reg      <= clr_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oid_reg   <= oid_next;
        ost_reg   <= ost_next;
        olast_reg <= olast_next;
        pend_reg  <= pend_next;
    end

    // finished marks, one bit per task
    always_ff @(posedge clk)
    begin
        if (fin_we)
        begin
            fin_mem[fin_waddr] <= fin_wdata;
        end
        fin_rd_reg <= fin_mem[fin_raddr];
    end

    assign out_ch.valid          = ov_reg;
    assign out_ch.payload.out_id = oid_reg;
    assign out_ch.payload.status = ost_reg;
    assign out_ch.payload.last   = olast_reg;
endmodule
